>>> hdl/sao_pkg.sv
// shared arc owner table: package with widths, codes and the queue item type
// used by the front, queue, back and top level files; no dependencies
`default_nettype none

package sao_pkg;

  // default sizes
  localparam int unsigned ArcSlotsDef    = 4096;
  localparam int unsigned FeatureBitsDef = 16;

  // fixed field widths
  localparam int unsigned CountW  = 13;
  localparam int unsigned RefW    = 13;
  localparam int unsigned IdxW    = RefW - 1;
  localparam int unsigned FeatInW = 16;
  localparam int unsigned OpW     = 2;

  // reset value of the arc count register
  localparam logic [CountW-1:0] CountReset = 13'd4096;

  // op codes on the input beat
  localparam logic [OpW-1:0] OpRecord = 2'd0;
  localparam logic [OpW-1:0] OpQuery  = 2'd1;
  localparam logic [OpW-1:0] OpClear  = 2'd2;

  // status codes on the result beat
  localparam logic StatusDone  = 1'b0;
  localparam logic StatusRange = 1'b1;

  // depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // classified item kinds
  typedef enum logic [2:0] {
    KindRecord,
    KindQuery,
    KindClear,
    KindNop,
    KindRange
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [IdxW-1:0]     idx;
    logic [FeatInW-1:0]  feature;
  } item_t;

  // result fields, status in the lowest bit
  typedef struct packed {
    logic shared;
    logic owned;
    logic status;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/sao_front.sv
// shared arc owner table: front end, decodes the arc reference and classifies
// each incoming beat; depends on sao_pkg
`default_nettype none

module sao_front #(
  parameter int unsigned ARC_SLOTS = sao_pkg::ArcSlotsDef
) (
  input  wire logic [sao_pkg::OpW-1:0]     op_i,
  input  wire logic [sao_pkg::FeatInW-1:0] feature_i,
  input  wire logic [sao_pkg::RefW-1:0]    arc_ref_i,
  input  wire logic [sao_pkg::CountW-1:0]  count_i,
  output      sao_pkg::item_t              item_o
);
  import sao_pkg::*;

  logic [IdxW-1:0] idx;
  logic [31:0]     idx_w;
  logic            in_range;

  // negative reference r names arc -r-1, which is the bitwise inverse
  assign idx   = arc_ref_i[RefW-1] ? ~arc_ref_i[IdxW-1:0] : arc_ref_i[IdxW-1:0];
  assign idx_w = 32'(idx);

  // below both the programmed count and the table size
  assign in_range = ({1'b0, idx} < count_i) && (idx_w < ARC_SLOTS);

  // classify
  always_comb begin
    item_o.idx     = idx;
    item_o.feature = feature_i;
    unique case (op_i)
      OpRecord: item_o.kind = in_range ? KindRecord : KindRange;
      OpQuery:  item_o.kind = in_range ? KindQuery : KindRange;
      OpClear:  item_o.kind = KindClear;
      default:  item_o.kind = KindNop;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/sao_queue.sv
// shared arc owner table: short queue of classified items between front and
// back; depends on sao_pkg
`default_nettype none

module sao_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sao_pkg::item_t item_i,
  output      logic           full_o,
  input  wire logic           pop_i,
  output      sao_pkg::item_t item_o,
  output      logic           empty_o
);
  import sao_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sao_back.sv
// shared arc owner table: back end, read-modify-write of the mark and owner
// memories, clearing sweep and result register; depends on sao_pkg
`default_nettype none

module sao_back #(
  parameter int unsigned ARC_SLOTS    = sao_pkg::ArcSlotsDef,
  parameter int unsigned FEATURE_BITS = sao_pkg::FeatureBitsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire sao_pkg::item_t item_i,
  output      logic           pop_o,
  output      logic           sweep_o,
  output      logic           res_valid_o,
  input  wire logic           res_ready_i,
  output      sao_pkg::res_t  res_o
);
  import sao_pkg::*;

  localparam int unsigned AddrW = $clog2(ARC_SLOTS);

  typedef enum logic [1:0] {
    StSweep,
    StIdle,
    StUpdate
  } state_e;

  state_e                  state_q;
  logic [AddrW-1:0]        sweep_q;
  logic                    res_valid_q;
  res_t                    res_q;
  item_t                   cur_q;

  // flags memory holds {shared, owned}; owner memory is never cleared
  logic [1:0]              flags_mem [ARC_SLOTS];
  logic [FEATURE_BITS-1:0] owner_mem [ARC_SLOTS];
  logic [1:0]              flags_rd_q;
  logic [FEATURE_BITS-1:0] owner_rd_q;

  logic [31:0]             pop_idx_w, cur_idx_w, feat_w;
  logic [AddrW-1:0]        pop_addr, cur_addr;
  logic [FEATURE_BITS-1:0] feat;
  logic                    is_record, take_owner;
  logic [1:0]              new_flags;

  assign pop_idx_w = 32'(item_i.idx);
  assign cur_idx_w = 32'(cur_q.idx);
  assign pop_addr  = pop_idx_w[AddrW-1:0];
  assign cur_addr  = cur_idx_w[AddrW-1:0];
  assign feat_w    = 32'(cur_q.feature);
  assign feat      = feat_w[FEATURE_BITS-1:0];

  // take an item when the result slot is free or draining
  assign pop_o = (state_q == StIdle) && !empty_i && (!res_valid_q || res_ready_i);

  // update of the read entry
  assign is_record  = (cur_q.kind == KindRecord);
  assign take_owner = is_record && !flags_rd_q[0];
  always_comb begin
    new_flags = flags_rd_q;
    if (is_record) begin
      if (!flags_rd_q[0]) begin
        new_flags[0] = 1'b1;
      end else if (owner_rd_q != feat) begin
        new_flags[1] = 1'b1;
      end
    end
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StSweep;
      sweep_q     <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (res_valid_q && res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        StSweep: begin
          if (sweep_q == AddrW'(ARC_SLOTS - 1)) begin
            sweep_q <= '0;
            state_q <= StIdle;
          end else begin
            sweep_q <= sweep_q + 1'b1;
          end
        end
        StIdle: begin
          if (pop_o) begin
            unique case (item_i.kind)
              KindRecord, KindQuery: begin
                state_q <= StUpdate;
              end
              KindClear: begin
                res_valid_q <= 1'b1;
                res_q       <= '0;
                state_q     <= StSweep;
              end
              KindRange: begin
                res_valid_q <= 1'b1;
                res_q       <= '{shared: 1'b0, owned: 1'b0, status: StatusRange};
              end
              default: begin
                res_valid_q <= 1'b1;
                res_q       <= '0;
              end
            endcase
          end
        end
        StUpdate: begin
          res_valid_q <= 1'b1;
          res_q       <= '{shared: new_flags[1], owned: new_flags[0], status: StatusDone};
          state_q     <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // item held during the update cycle
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= item_i;
    end
  end

  // flags memory: sweep clears, update writes, registered read on pop
  always_ff @(posedge clk_i) begin
    if (state_q == StSweep) begin
      flags_mem[sweep_q] <= 2'b00;
    end else if (state_q == StUpdate && is_record) begin
      flags_mem[cur_addr] <= new_flags;
    end
    if (pop_o) begin
      flags_rd_q <= flags_mem[pop_addr];
    end
  end

  // owner memory: written by the first reference only
  always_ff @(posedge clk_i) begin
    if (state_q == StUpdate && take_owner) begin
      owner_mem[cur_addr] <= feat;
    end
    if (pop_o) begin
      owner_rd_q <= owner_mem[pop_addr];
    end
  end

  assign sweep_o     = (state_q == StSweep);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> hdl/shared_arc_owner_table_core.sv
// shared arc owner table: top level with stream ports and the arc count
// register; depends on sao_pkg, sao_front, sao_queue and sao_back
`default_nettype none

// Tracks, per arc, which feature referenced it first and whether a second
// feature referenced it too, so shared arcs can be found.
// Input beat: s_axis_tuser carries op (0 record, 1 query, 2 clear);
// s_axis_tdata carries feature_index and arc_ref. Each input beat gives
// exactly one output beat on m_axis_tdata {shared, owned, status}.
// The user must write arc_count through cfg_we_i/cfg_wdata_i only while
// the block is idle; the block itself does not enforce it. A record or
// query beat is a read then a write of one memory entry in the back end:
// the registered read on pop, then the write-back that loads the result;
// no new item is taken until the write-back is done. Out-of-range, unused-op
// and clear beats load the result register directly. A clear beat starts a
// sweep over the mark memory; beats already queued wait, and s_axis_tready
// stays low while it runs. After reset the same sweep runs before any beat is taken.
// A stalled m_axis_tready holds the result register; the two-entry queue
// keeps accepting until full, then s_axis_tready drops.
module shared_arc_owner_table_core #(
  parameter int unsigned ARC_SLOTS    = sao_pkg::ArcSlotsDef,
  parameter int unsigned FEATURE_BITS = sao_pkg::FeatureBitsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration
  input  wire logic                       cfg_we_i,
  input  wire logic [sao_pkg::CountW-1:0] cfg_wdata_i,   // arc_count
  // input stream
  input  wire logic                       s_axis_tvalid,
  output      logic                       s_axis_tready,
  input  wire logic [31:0]                s_axis_tdata,  // feature_index[15:0], arc_ref[28:16]
  input  wire logic [sao_pkg::OpW-1:0]    s_axis_tuser,  // op[1:0]
  // result stream
  output      logic                       m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output      logic [7:0]                 m_axis_tdata   // status[0], owned[1], shared[2]
);
  import sao_pkg::*;

  logic [CountW-1:0] count_q;
  item_t             front_item, queue_item;
  logic              q_full, q_empty, push, pop, sweeping;
  res_t              res;

  // arc count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // front: decode and classify
  sao_front #(
    .ARC_SLOTS (ARC_SLOTS)
  ) u_front (
    .op_i      (s_axis_tuser),
    .feature_i (s_axis_tdata[FeatInW-1:0]),
    .arc_ref_i (s_axis_tdata[FeatInW+RefW-1:FeatInW]),
    .count_i   (count_q),
    .item_o    (front_item)
  );

  assign s_axis_tready = !q_full && !sweeping;
  assign push          = s_axis_tvalid && s_axis_tready;

  // queue between front and back
  sao_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (q_empty)
  );

  // back: table update and result
  sao_back #(
    .ARC_SLOTS    (ARC_SLOTS),
    .FEATURE_BITS (FEATURE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .item_i      (queue_item),
    .pop_o       (pop),
    .sweep_o     (sweeping),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {5'b00000, res};

endmodule

`default_nettype wire
